>>> src/first_fit_square_grid_allocator_macros.svh
// ----------------------------------------------------------------------------
// first_fit_square_grid_allocator_macros
// assertion macros shared by the checker of the square grid allocator
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_SQUARE_GRID_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SQUARE_GRID_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define FFSG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffsg check failed");

// next-cycle implication, checked outside reset
`define FFSG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffsg check failed");

`endif

>>> src/ffsg_pkg.sv
// ----------------------------------------------------------------------------
// ffsg_pkg
// types and constants shared by the square grid allocator modules
// ----------------------------------------------------------------------------
package ffsg_pkg;

	// width of geometry arithmetic (holds up to 256 plus a side)
	localparam int DW = 9;
	localparam int IN_W = 24;
	localparam int OUT_W = 32;
	localparam logic [10:0] COUNT_MAX = 11'd2047;

	// command kinds
	localparam logic KIND_PLACE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// configuration register indexes
	localparam logic REG_GRID_ROWS = 1'b0;
	localparam logic REG_GRID_COLS = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic chk;
		logic acc_rd;
		logic acc_or;
		logic col;
		logic fill_rd;
		logic fill_wr;
		logic cell_rd;
		logic out_load;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic go_scan;
		logic k_last;
		logic hit;
		logic col_end;
		logic row_end;
	} dp_sts_t;

endpackage

>>> src/first_fit_square_grid_allocator.sv
// A read passes the cell-read state, and a place with side zero, an empty area or a square
// too large only the check state, before the done state loads the result register.
// Per anchor row tried, a place scan reads and ORs side rows through the single memory
// read port, then tests the column anchors in the column state; a hit then fills side rows.
// One item at a time; the next item is taken once the result sits in the output register.
// Reset: asynchronous, clears the grid to empty, the count to zero, rows and cols to 32.
// ----------------------------------------------------------------------------
// first_fit_square_grid_allocator
// first-fit square placement on a tagged cell grid with cell readback
// ----------------------------------------------------------------------------
module first_fit_square_grid_allocator #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [5:0]                 cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// side[5:0], tag[13:6], cell_row[18:14], cell_col[23:19]
	input  logic [ffsg_pkg::IN_W-1:0]  s_tdata,
	// cmd[0]
	input  logic                       s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// placed[0], anchor_row[5:1], anchor_col[10:6], filled_cells[21:11],
	// cell_occupied[22], cell_tag[30:23], zero[31]
	output logic [ffsg_pkg::OUT_W-1:0] m_tdata
);
	import ffsg_pkg::*;

	logic [5:0] grid_rows_q, grid_cols_q;
	dp_cmd_t    cmd;
	dp_sts_t    sts;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= 6'd32;
			grid_cols_q <= 6'd32;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GRID_ROWS: grid_rows_q <= cfg_data;
				REG_GRID_COLS: grid_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ffsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.kind     (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffsg_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.grid_rows (grid_rows_q),
		.grid_cols (grid_cols_q),
		.kind      (s_tuser),
		.side      (s_tdata[5:0]),
		.tag       (s_tdata[13:6]),
		.cell_row  (s_tdata[18:14]),
		.cell_col  (s_tdata[23:19]),
		.cmd       (cmd),
		.sts       (sts),
		.res_q     (m_tdata)
	);

endmodule

>>> src/ffsg_dp.sv
// ----------------------------------------------------------------------------
// ffsg_dp
// datapath: occupancy and tag row memories, scan counters, fill and count
// ----------------------------------------------------------------------------
module ffsg_dp #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [5:0]              grid_rows,
	input  logic [5:0]              grid_cols,
	input  logic                    kind,
	input  logic [5:0]              side,
	input  logic [7:0]              tag,
	input  logic [4:0]              cell_row,
	input  logic [4:0]              cell_col,
	input  ffsg_pkg::dp_cmd_t       cmd,
	output ffsg_pkg::dp_sts_t       sts,
	output logic [ffsg_pkg::OUT_W-1:0] res_q
);
	import ffsg_pkg::*;

	localparam int RA_W = $clog2(MAX_ROWS);
	localparam int CA_W = $clog2(MAX_COLS);
	localparam logic [DW-1:0] MAXR = DW'(MAX_ROWS);
	localparam logic [DW-1:0] MAXC = DW'(MAX_COLS);

	logic                  kind_q;
	logic [5:0]            side_q;
	logic [7:0]            tag_q;
	logic [4:0]            crow_q;
	logic [4:0]            ccol_q;
	logic [MAX_COLS-1:0]   sqmask_q;
	logic [DW-1:0]         r_q, c_q, k_q;
	logic [MAX_COLS-1:0]   acc_q, shm_q, fill_q;
	logic                  placed_q;
	logic [10:0]           count_q;
	logic [MAX_ROWS-1:0]   row_vld_q;
	logic                  rd_vld_q;
	logic [MAX_COLS-1:0]   occ_rd_q;
	logic [MAX_COLS-1:0][7:0] tag_rd_q;

	logic [MAX_COLS-1:0]   occ_mem [MAX_ROWS];
	logic [MAX_COLS-1:0][7:0] tag_mem [MAX_ROWS];

	logic [DW-1:0]         rows_eff, cols_eff, side_ext, rowsum;
	logic [RA_W-1:0]       rd_addr, wr_addr;
	logic [MAX_COLS-1:0]   occ_eff, sqmask_d;
	logic [11:0]           prod;
	logic [12:0]           sum;
	logic [CA_W-1:0]       ccol_ix;
	logic                  in_range, cell_occ, trivial_ok;
	logic [7:0]            cell_tag;
	logic [4:0]            arow, acol;

	// effective area and geometry
	always_comb begin
		rows_eff = (DW'(grid_rows) > MAXR) ? MAXR : DW'(grid_rows);
		cols_eff = (DW'(grid_cols) > MAXC) ? MAXC : DW'(grid_cols);
		side_ext = DW'(side_q);
		rowsum = r_q + k_q;
		wr_addr = rowsum[RA_W-1:0];
		rd_addr = cmd.cell_rd ? RA_W'(crow_q) : rowsum[RA_W-1:0];
		occ_eff = rd_vld_q ? occ_rd_q : '0;
		trivial_ok = (side_q == 6'd0) && (rows_eff != '0) && (cols_eff != '0);
		prod = 12'(side_q * side_q);
		sum = {2'b00, count_q} + {1'b0, prod};
		for (int j = 0; j < MAX_COLS; j++) begin
			sqmask_d[j] = (DW'(j) < DW'(side));
		end
	end

	// status to the controller
	always_comb begin
		sts.go_scan = (side_q != 6'd0) && (side_ext <= rows_eff) && (side_ext <= cols_eff);
		sts.k_last = ((k_q + DW'(1)) == side_ext);
		sts.hit = ((acc_q & shm_q) == '0);
		sts.col_end = (c_q == (cols_eff - side_ext));
		sts.row_end = (r_q == (rows_eff - side_ext));
	end

	// item fields and square mask
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			side_q <= side;
			tag_q <= tag;
			crow_q <= cell_row;
			ccol_q <= cell_col;
			sqmask_q <= sqmask_d;
		end
	end

	// scan counters and masks
	always_ff @(posedge clk) begin
		if (cmd.chk) begin
			r_q <= '0;
			c_q <= '0;
			k_q <= '0;
			acc_q <= '0;
		end
		if (cmd.acc_or) begin
			acc_q <= acc_q | occ_eff;
			k_q <= k_q + DW'(1);
			c_q <= '0;
			shm_q <= sqmask_q;
		end
		if (cmd.col) begin
			if (sts.hit) begin
				fill_q <= shm_q;
				k_q <= '0;
			end else if (sts.col_end) begin
				r_q <= r_q + DW'(1);
				k_q <= '0;
				acc_q <= '0;
			end else begin
				c_q <= c_q + DW'(1);
				shm_q <= shm_q << 1;
			end
		end
		if (cmd.fill_wr) begin
			k_q <= k_q + DW'(1);
		end
	end

	// placed flag and filled-cell count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			placed_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (cmd.load) begin
				placed_q <= 1'b0;
			end
			if (cmd.chk) begin
				placed_q <= trivial_ok;
			end
			if (cmd.col && sts.hit) begin
				placed_q <= 1'b1;
				count_q <= (sum > 13'(COUNT_MAX)) ? COUNT_MAX : sum[10:0];
			end
		end
	end

	// row valid bits, a row never written reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.cell_rd || cmd.acc_rd || cmd.fill_rd) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
			if (cmd.fill_wr) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// occupancy and tag memories, one row read and one row written
	always_ff @(posedge clk) begin
		if (cmd.cell_rd || cmd.acc_rd || cmd.fill_rd) begin
			occ_rd_q <= occ_mem[rd_addr];
			tag_rd_q <= tag_mem[rd_addr];
		end
		if (cmd.fill_wr) begin
			occ_mem[wr_addr] <= occ_eff | fill_q;
			for (int j = 0; j < MAX_COLS; j++) begin
				if (fill_q[j]) begin
					tag_mem[wr_addr][j] <= tag_q;
				end
			end
		end
	end

	// result fields
	always_comb begin
		ccol_ix = CA_W'(ccol_q);
		in_range = (DW'(crow_q) < MAXR) && (DW'(ccol_q) < MAXC);
		cell_occ = (kind_q == KIND_READ) && in_range && occ_eff[ccol_ix];
		cell_tag = cell_occ ? tag_rd_q[ccol_ix] : 8'd0;
		arow = placed_q ? r_q[4:0] : 5'd0;
		acol = placed_q ? c_q[4:0] : 5'd0;
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q <= {1'b0, cell_tag, cell_occ, count_q, acol, arow, placed_q};
		end
	end

endmodule

>>> src/ffsg_ctrl.sv
// ----------------------------------------------------------------------------
// ffsg_ctrl
// controller: sequences the row scan, column scan, fill, cell read and result handoff
// ----------------------------------------------------------------------------
module ffsg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              kind,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  ffsg_pkg::dp_sts_t sts,
	output ffsg_pkg::dp_cmd_t cmd
);
	import ffsg_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_PCHK    = 9'b000000010,
		ST_ACC_RD  = 9'b000000100,
		ST_ACC_OR  = 9'b000001000,
		ST_COL     = 9'b000010000,
		ST_FILL_RD = 9'b000100000,
		ST_FILL_WR = 9'b001000000,
		ST_CELL_RD = 9'b010000000,
		ST_DONE    = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d = (kind == KIND_READ) ? ST_CELL_RD : ST_PCHK;
				end
			end
			ST_PCHK: begin
				cmd.chk = 1'b1;
				state_d = sts.go_scan ? ST_ACC_RD : ST_DONE;
			end
			ST_ACC_RD: begin
				cmd.acc_rd = 1'b1;
				state_d = ST_ACC_OR;
			end
			ST_ACC_OR: begin
				cmd.acc_or = 1'b1;
				state_d = sts.k_last ? ST_COL : ST_ACC_RD;
			end
			ST_COL: begin
				cmd.col = 1'b1;
				if (sts.hit) begin
					state_d = ST_FILL_RD;
				end else if (sts.col_end) begin
					state_d = sts.row_end ? ST_DONE : ST_ACC_RD;
				end
			end
			ST_FILL_RD: begin
				cmd.fill_rd = 1'b1;
				state_d = ST_FILL_WR;
			end
			ST_FILL_WR: begin
				cmd.fill_wr = 1'b1;
				state_d = sts.k_last ? ST_DONE : ST_FILL_RD;
			end
			ST_CELL_RD: begin
				cmd.cell_rd = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/ffsg_chk.sv
// ----------------------------------------------------------------------------
// ffsg_chk
// port checker for the square grid allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "first_fit_square_grid_allocator_macros.svh"

module ffsg_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [ffsg_pkg::OUT_W-1:0] m_tdata
);
	import ffsg_pkg::*;

	// a stalled result holds
	`FFSG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`FFSG_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
	// one item in flight: no accept right after an accept
	`FFSG_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
	// a failed or read result carries a zero anchor
	`FFSG_ASSERT_NOW(a_anchor_zero, m_tvalid && !m_tdata[0], m_tdata[10:1] == 10'd0)
	// a placement never reports a cell read
	`FFSG_ASSERT_NOW(a_place_no_cell, m_tvalid && m_tdata[0], m_tdata[30:22] == 9'd0)

endmodule

bind first_fit_square_grid_allocator ffsg_chk u_ffsg_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
